// ===== rtl/core/sed_pkg.sv =====
// Package with the transaction types, decoder state and character helpers.
`default_nettype none

package sed_pkg;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [7:0]  byte_value;
      logic        byte_valid;
      logic        end_of_string;
      logic        incomplete_escape;
      logic [15:0] byte_count;
   } rsp_type;

   typedef struct packed {
      logic    emit;
      rsp_type rsp;
   } dec_result_type;

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_ESC   = 2'd1,
      MODE_HEX1  = 2'd2,
      MODE_HEX2  = 2'd3
   } mode_type;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOWER_X   = 8'h78;
   localparam logic [7:0] CHAR_UPPER_X   = 8'h58;
   localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
   localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHAR_LOWER_V   = 8'h76;
   localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9   = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F   = 8'h46;

   localparam logic [7:0] CODE_BACKSPACE = 8'd8;
   localparam logic [7:0] CODE_FORMFEED  = 8'd12;
   localparam logic [7:0] CODE_NEWLINE   = 8'd10;
   localparam logic [7:0] CODE_RETURN    = 8'd13;
   localparam logic [7:0] CODE_TAB       = 8'd9;
   localparam logic [7:0] CODE_VTAB      = 8'd11;

   function automatic logic is_hex(input logic [7:0] c);
      return ((c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9)) ||
             ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F)) ||
             ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F));
   endfunction

   // Returns zero for a character that is not a hex digit.
   function automatic logic [3:0] hex_digit(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if ((c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9)) begin
         d = c - CHAR_DIGIT_0;
      end else if ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F)) begin
         d = c - CHAR_LOWER_A + 8'd10;
      end else if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F)) begin
         d = c - CHAR_UPPER_A + 8'd10;
      end
      return d[3:0];
   endfunction

   function automatic logic [7:0] escape_value(input logic [7:0] c);
      logic [7:0] v;
      unique case (c)
         CHAR_LOWER_B: v = CODE_BACKSPACE;
         CHAR_LOWER_F: v = CODE_FORMFEED;
         CHAR_LOWER_N: v = CODE_NEWLINE;
         CHAR_LOWER_R: v = CODE_RETURN;
         CHAR_LOWER_T: v = CODE_TAB;
         CHAR_LOWER_V: v = CODE_VTAB;
         default:      v = c;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sed_decode.sv =====
// Escape decoding state machine with the saturating byte counter.
`default_nettype none

module sed_decode #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sed_pkg::req_type       item,
   input  wire logic                   consume,
   output sed_pkg::dec_result_type     result
);
   import sed_pkg::*;

   localparam int WIDE_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   mode_type              mode_ff, mode_in;
   logic [3:0]            digit_ff, digit_in;
   logic                  good_ff, good_in;
   logic [COUNT_BITS-1:0] count_ff, count_in, count_inc;
   logic [WIDE_BITS-1:0]  count_wide;
   logic [7:0]            c;
   logic                  last;

   assign c         = item.char_code;
   assign last      = item.last_char;
   assign count_inc = (&count_ff) ? count_ff : count_ff + COUNT_BITS'(1);
   assign count_wide = WIDE_BITS'(count_inc);

   always_comb begin
      mode_in  = mode_ff;
      digit_in = digit_ff;
      good_in  = good_ff;
      count_in = count_ff;
      if (last) begin
         mode_in  = MODE_PLAIN;
         digit_in = 4'd0;
         good_in  = 1'b0;
         count_in = '0;
      end else begin
         unique case (mode_ff)
            MODE_PLAIN: begin
               if (c == CHAR_BACKSLASH) begin
                  mode_in = MODE_ESC;
               end else begin
                  count_in = count_inc;
               end
            end
            MODE_ESC: begin
               if ((c == CHAR_LOWER_X) || (c == CHAR_UPPER_X)) begin
                  mode_in = MODE_HEX1;
               end else begin
                  mode_in  = MODE_PLAIN;
                  count_in = count_inc;
               end
            end
            MODE_HEX1: begin
               mode_in  = MODE_HEX2;
               digit_in = hex_digit(c);
               good_in  = is_hex(c);
            end
            MODE_HEX2: begin
               mode_in  = MODE_PLAIN;
               digit_in = 4'd0;
               good_in  = 1'b0;
               count_in = count_inc;
            end
            default: mode_in = MODE_PLAIN;
         endcase
      end
   end

   always_comb begin
      result.emit                  = 1'b1;
      result.rsp.byte_value        = 8'd0;
      result.rsp.byte_valid        = 1'b1;
      result.rsp.end_of_string     = last;
      result.rsp.incomplete_escape = 1'b0;
      result.rsp.byte_count        = (count_wide > WIDE_BITS'(16'hFFFF)) ?
                                     16'hFFFF : count_wide[15:0];
      unique case (mode_ff)
         MODE_PLAIN: begin
            if (c == CHAR_BACKSLASH) begin
               result.emit                  = last;
               result.rsp.incomplete_escape = last;
            end else begin
               result.rsp.byte_value = c;
            end
         end
         MODE_ESC: begin
            if ((c == CHAR_LOWER_X) || (c == CHAR_UPPER_X)) begin
               result.emit                  = last;
               result.rsp.incomplete_escape = last;
            end else begin
               result.rsp.byte_value = escape_value(c);
            end
         end
         MODE_HEX1: begin
            result.emit           = last;
            result.rsp.byte_value = {4'd0, hex_digit(c)};
         end
         MODE_HEX2: begin
            result.rsp.byte_value = (good_ff && is_hex(c)) ?
                                    {digit_ff, hex_digit(c)} : 8'd0;
         end
         default: result.emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_PLAIN;
         digit_ff <= 4'd0;
         good_ff  <= 1'b0;
         count_ff <= '0;
      end else if (consume) begin
         mode_ff  <= mode_in;
         digit_ff <= digit_in;
         good_ff  <= good_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/string_escape_decoder.sv =====
// Top level of the string escape decoder: input register, decoder and result register.
`default_nettype none

// Takes one character of a literal body per transaction and returns at most one
// decoded byte per transaction, with the literal's running byte count. It accepts
// a transaction in every cycle in which req_stall is low. A character is held in
// the input register and its result is then loaded into the result register,
// which offers it on rsp_valid until it is taken. Characters that only open an
// escape (backslash, x or X) and the first hex digit return nothing unless they
// end the literal. req_stall rises only while a finished result waits under
// rsp_stall in the result register and the character held in the input register produces one.

module string_escape_decoder #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sed_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sed_pkg::rsp_type      rsp_payload
);
   import sed_pkg::*;

   logic           s1_valid_ff, s1_valid_in;
   req_type        s1_data_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff;
   dec_result_type dec_result;
   logic           out_free, s1_advance, accept, load;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && (!dec_result.emit || out_free);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign accept     = req_valid && !req_stall;
   assign load       = s1_advance && dec_result.emit;

   assign s1_valid_in  = accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = load ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);

   sed_decode #(
      .COUNT_BITS(COUNT_BITS)
   ) u_decode (
      .clock  (clock),
      .reset  (reset),
      .item   (s1_data_ff),
      .consume(s1_advance),
      .result (dec_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= dec_result.rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`ifndef SYNTHESIS
   a_incomplete_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.incomplete_escape |->
         rsp_payload.end_of_string && (rsp_payload.byte_value == 8'd0))
      else $error("incomplete escape result does not close the literal with zero");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.byte_count != 16'd0) && rsp_payload.byte_valid)
      else $error("result carries a zero byte count or no valid byte");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("result register loaded while holding an untaken result");
`endif

endmodule

`default_nettype wire
